// ===== rtl/indexed_shift_list_assert.svh =====
// Assertion macros for the indexed shift list checker.
// Depends on nothing; included by the checker file only.
`ifndef INDEXED_SHIFT_LIST_ASSERT_SVH
`define INDEXED_SHIFT_LIST_ASSERT_SVH

// Implication checked at every rising edge outside reset.
`define ISL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, also active during reset.
`define ISL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/isl_pkg.sv =====
// Shared types and codes for the indexed shift list.
// Used by isl_cell, indexed_shift_list and its checker.
`default_nettype none

package isl_pkg;

  // Operation codes on the input channel
  localparam logic [2:0] FN_PUSH   = 3'd0;
  localparam logic [2:0] FN_GET    = 3'd1;
  localparam logic [2:0] FN_ERASE  = 3'd2;
  localparam logic [2:0] FN_INSERT = 3'd3;
  localparam logic [2:0] FN_UPDATE = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Cell actions broadcast along the row
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_PUSH   = 3'd1;
  localparam logic [2:0] ACT_ERASE  = 3'd2;
  localparam logic [2:0] ACT_INSERT = 3'd3;
  localparam logic [2:0] ACT_UPDATE = 3'd4;

  // Source of the read word in a result
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_CELL = 2'd1;
  localparam logic [1:0] RD_ONES = 2'd2;

  // Widths fixed by the item fields and the largest supported row
  localparam int WORD_W = 32;
  localparam int POS_W  = 7;
  localparam int CNT_W  = 13;

  // Command seen by every cell in the row
  typedef struct packed {
    logic [2:0]        act;
    logic [POS_W-1:0]  pos;
    logic [CNT_W-1:0]  cnt;
    logic [WORD_W-1:0] word;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/isl_cell.sv =====
// One storage cell of the indexed shift list row.
// Depends on isl_pkg for the command struct and action codes.
`default_nettype none

module isl_cell #(
  parameter int IDX = 0
) (
  input  wire logic                       clk,
  input  wire isl_pkg::cmd_t              cmd,
  input  wire logic [isl_pkg::WORD_W-1:0] upper_i,
  input  wire logic [isl_pkg::WORD_W-1:0] lower_i,
  output logic      [isl_pkg::WORD_W-1:0] word_o,
  output logic      [isl_pkg::WORD_W-1:0] rd_o
);

  logic [isl_pkg::WORD_W-1:0] word_r;
  logic [isl_pkg::WORD_W-1:0] word_nxt;
  logic [31:0]                idx;
  logic [31:0]                pos;
  logic [31:0]                cnt;

  assign idx = 32'(IDX);
  assign pos = 32'(cmd.pos);
  assign cnt = 32'(cmd.cnt);

  // Pick the next word from hold, new word, neighbor or clear
  always_comb begin
    word_nxt = word_r;
    unique case (cmd.act)
      isl_pkg::ACT_PUSH: begin
        if (idx == cnt) word_nxt = cmd.word;
      end
      isl_pkg::ACT_ERASE: begin
        if (idx + 32'd1 == cnt) word_nxt = '0;
        else if (idx >= pos && idx + 32'd1 < cnt) word_nxt = upper_i;
      end
      isl_pkg::ACT_INSERT: begin
        if (idx == pos) word_nxt = cmd.word;
        else if (idx > pos && idx <= cnt) word_nxt = lower_i;
      end
      isl_pkg::ACT_UPDATE: begin
        if (idx == pos) word_nxt = cmd.word;
      end
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o = word_r;

  // Drive the stored word only when this cell is addressed
  assign rd_o = (idx == pos) ? word_r : '0;

endmodule

`default_nettype wire

// ===== rtl/indexed_shift_list.sv =====
// Indexed shift list: top level with a row of isl_cell storage cells.
// Depends on isl_pkg and isl_cell.
// A result passes through stage A, stage B and the output register.
// One item in flight: a new item is taken once stages A and B are empty; the result sits
// in an output register, so a stalled result does not block the next item.
// A get read goes through a two-level OR tree registered after 16-cell groups.
// Reset clears the count and all valid flags; cell contents are not cleared.
`default_nettype none

module indexed_shift_list #(
  parameter int CAPACITY = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_func,
  input  wire logic [6:0]  in_position,
  input  wire logic [31:0] in_word_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [31:0]      out_word_out,
  output logic [7:0]       out_count_out
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int GRP  = 16;
  localparam int NGRP = (CAPACITY + GRP - 1) / GRP;

  // Stage A: accepted item
  logic                       a_vld_r;
  logic [2:0]                 a_func_r;
  logic [isl_pkg::POS_W-1:0]  a_pos_r;
  logic [isl_pkg::WORD_W-1:0] a_word_r;

  // List length
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  // Stage B: read partials and result fields
  logic                       b_vld_r;
  logic [isl_pkg::WORD_W-1:0] b_part_r [NGRP];
  logic [1:0]                 b_status_r;
  logic [1:0]                 b_sel_r;
  logic [7:0]                 b_count_r;

  // Output register
  logic        out_vld_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_word_r;
  logic [7:0]  out_count_r;

  // Stage A decode
  isl_pkg::cmd_t cmd;
  logic [1:0]    status_w;
  logic [1:0]    sel_w;
  logic [2:0]    act_w;
  logic          inrange;
  logic          full;

  // Row wiring
  logic [isl_pkg::WORD_W-1:0] cell_w [CAPACITY];
  logic [isl_pkg::WORD_W-1:0] rd_w   [CAPACITY];
  logic [isl_pkg::WORD_W-1:0] part_w [NGRP];
  logic [isl_pkg::WORD_W-1:0] rd_all;

  logic b_take;

  assign in_stall = a_vld_r | b_vld_r;
  assign b_take   = b_vld_r & (~out_vld_r | ~out_stall);

  // Check the index and capacity, pick the cell action
  always_comb begin
    inrange   = 32'(a_pos_r) < 32'(count_r);
    full      = 32'(count_r) >= 32'(CAPACITY);
    status_w  = isl_pkg::ST_OK;
    sel_w     = isl_pkg::RD_ZERO;
    act_w     = isl_pkg::ACT_NONE;
    count_nxt = count_r;
    unique case (a_func_r)
      isl_pkg::FN_PUSH: begin
        if (full) status_w = isl_pkg::ST_FULL;
        else begin
          act_w     = isl_pkg::ACT_PUSH;
          count_nxt = count_r + CW'(1);
        end
      end
      isl_pkg::FN_GET: begin
        if (inrange) sel_w = isl_pkg::RD_CELL;
        else begin
          status_w = isl_pkg::ST_RANGE;
          sel_w    = isl_pkg::RD_ONES;
        end
      end
      isl_pkg::FN_ERASE: begin
        if (inrange) begin
          act_w     = isl_pkg::ACT_ERASE;
          count_nxt = count_r - CW'(1);
        end else status_w = isl_pkg::ST_RANGE;
      end
      isl_pkg::FN_INSERT: begin
        if (!inrange) status_w = isl_pkg::ST_RANGE;
        else if (full) status_w = isl_pkg::ST_FULL;
        else begin
          act_w     = isl_pkg::ACT_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      isl_pkg::FN_UPDATE: begin
        if (inrange) act_w = isl_pkg::ACT_UPDATE;
        else status_w = isl_pkg::ST_RANGE;
      end
      default: status_w = isl_pkg::ST_OK;
    endcase
    cmd.act  = a_vld_r ? act_w : isl_pkg::ACT_NONE;
    cmd.pos  = a_pos_r;
    cmd.cnt  = isl_pkg::CNT_W'(count_r);
    cmd.word = a_word_r;
  end

  // Build the row; the ends see zero beyond them
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [isl_pkg::WORD_W-1:0] upper;
    logic [isl_pkg::WORD_W-1:0] lower;
    if (i + 1 < CAPACITY) begin : g_up
      assign upper = cell_w[i+1];
    end else begin : g_up_end
      assign upper = '0;
    end
    if (i > 0) begin : g_lo
      assign lower = cell_w[i-1];
    end else begin : g_lo_end
      assign lower = '0;
    end
    isl_cell #(.IDX(i)) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .upper_i (upper),
      .lower_i (lower),
      .word_o  (cell_w[i]),
      .rd_o    (rd_w[i])
    );
  end

  // OR the addressed word within each group
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_w[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) part_w[g] = part_w[g] | rd_w[g * GRP + k];
      end
    end
  end

  // Merge the registered group partials
  always_comb begin
    rd_all = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_all = rd_all | b_part_r[g];
    end
  end

  // Control: stage valids, count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r   <= 1'b0;
      b_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
      count_r   <= '0;
    end else begin
      a_vld_r <= in_valid & ~in_stall;
      if (a_vld_r) begin
        b_vld_r <= 1'b1;
        count_r <= count_nxt;
      end else if (b_take) begin
        b_vld_r <= 1'b0;
      end
      if (b_take) out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  // Payload: capture the item, stage B fields and the result
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_func_r <= in_func;
      a_pos_r  <= in_position;
      a_word_r <= in_word_in;
    end
    if (a_vld_r) begin
      b_part_r   <= part_w;
      b_status_r <= status_w;
      b_sel_r    <= sel_w;
      b_count_r  <= 8'(count_nxt);
    end
    if (b_take) begin
      out_status_r <= b_status_r;
      out_count_r  <= b_count_r;
      unique case (b_sel_r)
        isl_pkg::RD_CELL: out_word_r <= rd_all;
        isl_pkg::RD_ONES: out_word_r <= '1;
        default:          out_word_r <= '0;
      endcase
    end
  end

  assign out_valid     = out_vld_r;
  assign out_status    = out_status_r;
  assign out_word_out  = out_word_r;
  assign out_count_out = out_count_r;

endmodule

`default_nettype wire

// ===== rtl/isl_checker.sv =====
// Port-level checker for indexed_shift_list, bound to the top level.
// Depends on isl_pkg and the assertion macros in indexed_shift_list_assert.svh.
`default_nettype none
`include "indexed_shift_list_assert.svh"

module isl_checker #(
  parameter int CAPACITY = 128
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_word_out,
  input wire logic [7:0]  out_count_out
);

  // A stalled result stays offered
  `ISL_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  // One item in flight: the cycle after an accept the input is stalled
  `ISL_ASSERT(a_one_item, clk, rst_n, in_valid && !in_stall |=> in_stall, "second item taken while busy")

  // No status code beyond the defined ones
  `ISL_ASSERT(a_status_code, clk, rst_n, out_valid |-> out_status != 2'd3, "undefined status code")

  // A full result leaves the list at capacity and reads nothing
  `ISL_ASSERT(a_full_res, clk, rst_n, out_valid && out_status == isl_pkg::ST_FULL |-> out_word_out == 32'd0 && out_count_out == 8'(CAPACITY), "bad full result")

  // No result offered in the cycle after reset
  `ISL_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind indexed_shift_list isl_checker #(.CAPACITY(CAPACITY)) u_isl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_status    (out_status),
  .out_word_out  (out_word_out),
  .out_count_out (out_count_out)
);

`default_nettype wire
